[rtl/core/wedm_pkg.sv]
// Package for the windowed error degradation monitor.
// Holds command codes, level masks and decision limits; no dependencies.
package wedm_pkg;

   localparam int CMD_W = 3;
   localparam int CAT_W = 3;
   localparam int LVL_W = 2;
   localparam int FEAT_W = 3;
   localparam int MASK_W = 6;
   localparam int TOTAL_W = 10;
   localparam int NOW_W = 32;
   localparam int THR_W = 8;
   localparam int WIN_W = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_REPORT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLDS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW     = 1'd1;

   localparam logic [CSR_DATA_W-1:0] THRESHOLDS_RESET = 64'h0201_0805_0103_0A05;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd60;

   localparam logic [CAT_W-1:0] CAT_THREAD   = 3'd3;
   localparam logic [CAT_W-1:0] CAT_INTERNAL = 3'd7;
   localparam logic [CAT_W-1:0] CAT_LAST     = 3'd7;

   localparam logic [FEAT_W-1:0] FEAT_COUNT = 3'd6;

   localparam int CRIT_L3 = 10;
   localparam int TOTAL_L3 = 50;
   localparam int CRIT_L2 = 5;
   localparam int TOTAL_L2 = 25;
   localparam int CRIT_L1 = 2;
   localparam int TOTAL_L1 = 10;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 10'd1023;

   typedef logic [MASK_W-1:0] mask_type;

   function automatic mask_type level_mask(input logic [LVL_W-1:0] lvl);
      mask_type m;
      unique case (lvl)
         2'd1: m = 6'h06;
         2'd2: m = 6'h1E;
         2'd3: m = 6'h3F;
         default: m = 6'h00;
      endcase
      return m;
   endfunction

endpackage

[rtl/core/windowed_error_degradation_monitor_top.sv]
// Top level of the windowed error degradation monitor.
// Depends on wedm_pkg; holds the time store memory and the sequencer.
//
// Usage:
//   Input channel req_*: one transaction carries a command (report, check,
//   set level, enable or disable feature) with category, time, level and
//   feature fields. Accepted when req_valid is high and req_stall is low.
//   Result channel rsp_*: exactly one transaction per input, carrying the
//   level, disabled feature mask, auto-raise flag and windowed total.
//   csr_*: plain write port; index 0 thresholds, index 1 window length.
//   Write only while idle.
// Sequence:
//   One item at a time. A report or check with now at or past the window
//   length walks all eight category stores through one memory read port:
//   in each category every stored entry is read, then compared and
//   compacted, and a last read step closes the category. Then comes the
//   counting, one shared adder/compare pass per category, one decision
//   step and one result step; other commands, and now below the window
//   length, skip the walk. The next request can be taken in the cycle
//   after the result leaves.
// Reset: synchronous, active high; clears counts, heads, level and mask,
//   restores register defaults. The time memory needs no clearing.
// Stall: a result held by rsp_stall stays in the output register; no new
//   item is taken until it has gone.
module windowed_error_degradation_monitor_top #(
   parameter int SLOTS_PER_CATEGORY = 64,
   parameter int TIME_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [wedm_pkg::CMD_W-1:0] req_command,
   input  logic [wedm_pkg::CAT_W-1:0] req_category,
   input  logic [wedm_pkg::NOW_W-1:0] req_now_time,
   input  logic [wedm_pkg::LVL_W-1:0] req_new_level,
   input  logic [wedm_pkg::FEAT_W-1:0] req_feature_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [wedm_pkg::LVL_W-1:0] rsp_level,
   output logic [wedm_pkg::MASK_W-1:0] rsp_disabled_mask,
   output logic rsp_level_raised,
   output logic [wedm_pkg::TOTAL_W-1:0] rsp_windowed_total,
   input  logic csr_write_enable,
   input  logic [wedm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wedm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import wedm_pkg::*;

   localparam int CATS = 8;
   localparam int SLOT_W = (SLOTS_PER_CATEGORY > 1) ? $clog2(SLOTS_PER_CATEGORY) : 1;
   localparam int CNT_W = $clog2(SLOTS_PER_CATEGORY + 1);
   localparam int DEPTH = CATS * SLOTS_PER_CATEGORY;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W = $clog2(2 * DEPTH + 1);
   localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int WIDE_W = 65;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_CMP    = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // slot index of (base + off) within one circular category store
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(SLOTS_PER_CATEGORY)) begin
         s = s - (CNT_W+1)'(SLOTS_PER_CATEGORY);
      end
      return s[SLOT_W-1:0];
   endfunction

   logic [2:0] state_ff, state_in;
   logic [CAT_W-1:0] cat_ff, cat_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [TIME_BITS-1:0] cutoff_ff, cutoff_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [SLOT_W-1:0] head_ff [CATS];
   logic [SLOT_W-1:0] head_in [CATS];
   logic [CNT_W-1:0] count_ff [CATS];
   logic [CNT_W-1:0] count_in [CATS];
   logic [LVL_W-1:0] level_ff, level_in;
   mask_type mask_ff, mask_in;
   logic [SUM_W-1:0] total_ff, total_in;
   logic [SUM_W-1:0] crit_ff, crit_in;
   logic raised_ff, raised_in;
   logic [CSR_DATA_W-1:0] thr_ff;
   logic [WIN_W-1:0] win_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0] rsp_level_ff;
   mask_type rsp_mask_ff;
   logic rsp_raised_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic [TIME_BITS-1:0] mem [DEPTH];
   logic [TIME_BITS-1:0] rdata_ff;

   logic accept;
   logic [CAT_W-1:0] sel_cat;
   logic [SLOT_W-1:0] sel_head;
   logic [CNT_W-1:0] sel_count;
   logic [SLOT_W-1:0] wr_slot, rd_slot, head_next;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [TIME_BITS-1:0] wr_data;
   logic [TIME_BITS-1:0] now_eff;
   logic [WIDE_W-1:0] now_wide, win_wide, diff_wide;
   logic mem_we;
   logic keep;
   logic [CMP_W-1:0] n_cmp, thr_cmp;
   logic [LVL_W-1:0] target;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   assign now_wide = WIDE_W'(req_now_time);
   assign now_eff = now_wide[TIME_BITS-1:0];
   assign win_wide = WIDE_W'(win_ff);
   assign diff_wide = WIDE_W'(now_eff) - win_wide;

   // one category index serves both the append and the scan
   assign sel_cat = (state_ff == ST_IDLE) ? req_category : cat_ff;
   assign sel_head = head_ff[sel_cat];
   assign sel_count = count_ff[sel_cat];

   always_comb begin
      if ((SLOT_W+1)'(sel_head) + (SLOT_W+1)'(1) >= (SLOT_W+1)'(SLOTS_PER_CATEGORY)) begin
         head_next = '0;
      end else begin
         head_next = sel_head + SLOT_W'(1);
      end
   end

   // append goes after the last entry; compaction writes kept entries in place
   assign wr_slot = slot_add(sel_head, (state_ff == ST_IDLE) ? sel_count : kept_ff);
   assign rd_slot = slot_add(sel_head, scan_ff);
   assign keep = !(rdata_ff < cutoff_ff);
   assign wr_data = (state_ff == ST_IDLE) ? now_eff : rdata_ff;

   assign wr_addr = ADDR_W'(sel_cat) * ADDR_W'(SLOTS_PER_CATEGORY) + ADDR_W'(wr_slot);
   assign rd_addr = ADDR_W'(sel_cat) * ADDR_W'(SLOTS_PER_CATEGORY) + ADDR_W'(rd_slot);
   assign mem_we = (accept && (req_command == CMD_REPORT)) || (state_ff == ST_CMP && keep);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_READ) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign n_cmp = CMP_W'(sel_count);
   assign thr_cmp = CMP_W'(thr_ff[cat_ff*THR_W +: THR_W]);

   always_comb begin
      target = 2'd0;
      if (crit_ff != '0) begin
         if (crit_ff >= SUM_W'(CRIT_L3) || total_ff >= SUM_W'(TOTAL_L3)) begin
            target = 2'd3;
         end else if (crit_ff >= SUM_W'(CRIT_L2) || total_ff >= SUM_W'(TOTAL_L2)) begin
            target = 2'd2;
         end else if (crit_ff >= SUM_W'(CRIT_L1) || total_ff >= SUM_W'(TOTAL_L1)) begin
            target = 2'd1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cat_in = cat_ff;
      cmd_in = cmd_ff;
      cutoff_in = cutoff_ff;
      scan_in = scan_ff;
      kept_in = kept_ff;
      head_in = head_ff;
      count_in = count_ff;
      level_in = level_ff;
      mask_in = mask_ff;
      total_in = total_ff;
      crit_in = crit_ff;
      raised_in = raised_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               cat_in = '0;
               scan_in = '0;
               kept_in = '0;
               total_in = '0;
               crit_in = '0;
               raised_in = 1'b0;
               cutoff_in = diff_wide[TIME_BITS-1:0];
               state_in = ST_SUM;
               case (req_command) inside
                  CMD_REPORT, CMD_CHECK: begin
                     if (req_command == CMD_REPORT) begin
                        if (sel_count == CNT_W'(SLOTS_PER_CATEGORY)) begin
                           head_in[req_category] = head_next;
                        end else begin
                           count_in[req_category] = sel_count + CNT_W'(1);
                        end
                     end
                     // nothing expires while now is below the window length
                     if (!diff_wide[WIDE_W-1]) begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_SET: begin
                     level_in = req_new_level;
                     mask_in = (req_new_level == 2'd0) ? '0 :
                               (mask_ff | level_mask(req_new_level));
                  end
                  CMD_ENABLE: begin
                     if (req_feature_index < FEAT_COUNT) begin
                        mask_in[req_feature_index] = 1'b0;
                     end
                  end
                  CMD_DISABLE: begin
                     if (req_feature_index < FEAT_COUNT) begin
                        mask_in[req_feature_index] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // every entry of the category is visited; survivors close up in order
            if (scan_ff == sel_count) begin
               count_in[cat_ff] = kept_ff;
               scan_in = '0;
               kept_in = '0;
               cat_in = cat_ff + CAT_W'(1);
               if (cat_ff == CAT_LAST) begin
                  state_in = ST_SUM;
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_READ;
            scan_in = scan_ff + CNT_W'(1);
            if (keep) begin
               kept_in = kept_ff + CNT_W'(1);
            end
         end
         ST_SUM: begin
            total_in = total_ff + SUM_W'(sel_count);
            crit_in = crit_ff
                    + ((cat_ff == CAT_THREAD || cat_ff == CAT_INTERNAL) ?
                       SUM_W'(sel_count) : SUM_W'(0))
                    + ((n_cmp >= thr_cmp) ? SUM_W'(sel_count) : SUM_W'(0));
            cat_in = cat_ff + CAT_W'(1);
            if (cat_ff == CAT_LAST) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if ((cmd_ff == CMD_REPORT || cmd_ff == CMD_CHECK) && target > level_ff) begin
               level_in = target;
               mask_in = mask_ff | level_mask(target);
               raised_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
         mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff <= THRESHOLDS_RESET;
         win_ff <= WINDOW_RESET;
         for (int i = 0; i < CATS; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         mask_ff <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         count_ff <= count_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_THRESHOLDS: thr_ff <= csr_write_data;
               REG_WINDOW: win_ff <= csr_write_data[WIN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cat_ff <= cat_in;
      cmd_ff <= cmd_in;
      cutoff_ff <= cutoff_in;
      scan_ff <= scan_in;
      kept_ff <= kept_in;
      total_ff <= total_in;
      crit_ff <= crit_in;
      raised_ff <= raised_in;
      if (state_ff == ST_DONE) begin
         rsp_level_ff <= level_ff;
         rsp_mask_ff <= mask_ff;
         rsp_raised_ff <= raised_ff;
         rsp_total_ff <= (total_ff > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : total_ff[TOTAL_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_disabled_mask = rsp_mask_ff;
   assign rsp_level_raised = rsp_raised_ff;
   assign rsp_windowed_total = rsp_total_ff;

   // a new result only follows the finishing step of the sequencer
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the finishing step");

   // the level only moves on a decision step or an accepted set command
   a_level_src: assert property (@(posedge clock) disable iff (reset)
      (level_ff != $past(level_ff)) |->
         ($past(state_ff) == ST_DECIDE || ($past(accept) && $past(req_command) == CMD_SET)))
      else $error("level changed without a cause");

   // auto raise only ever lifts the level
   a_raise_up: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && raised_in) |=> level_ff > $past(level_ff))
      else $error("automatic change did not raise the level");

endmodule
